// ----- rtl/swds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swds_pkg - stepper wave drive sequencer package
// Field widths, command and status codes, and default constants.
// ----------------------------------------------------------------------------
package swds_pkg;

  localparam int unsigned KIND_W    = 1;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned COILS_W   = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned STEPS_W   = 17;

  localparam int unsigned STEPS_PER_REV_DEF = 512;
  localparam int unsigned DEG_PER_REV       = 360;

  localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = TICKS_W'(1);
  localparam logic [STEPS_W-1:0] STEPS_MAX       = {STEPS_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_TICK = 1'b0;
  localparam logic [KIND_W-1:0] KIND_MOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_ACCEPT  = 2'd1,
    STATUS_BUSY    = 2'd2,
    STATUS_BAD_DIR = 2'd3
  } status_e;

endpackage

// ----- rtl/swds_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swds_cmd_if - input item channel
// Valid/ready channel carrying one tick or move command per item.
// ----------------------------------------------------------------------------
interface swds_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [swds_pkg::KIND_W-1:0]   kind;
  logic [swds_pkg::DIR_W-1:0]    direction;
  logic [swds_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output kind, output direction, output angle, input ready);
  modport sink   (input valid, input kind, input direction, input angle, output ready);
endinterface

// ----- rtl/swds_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swds_res_if - result item channel
// Valid/ready channel carrying coil drive and move status per item.
// ----------------------------------------------------------------------------
interface swds_res_if;
  logic                           valid;
  logic                           ready;
  logic [swds_pkg::COILS_W-1:0]   coils;
  logic                           busy_res;
  logic                           done_res;
  logic [swds_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output coils, output busy_res, output done_res,
                  output status, input ready);
  modport sink   (input valid, input coils, input busy_res, input done_res,
                  input status, output ready);
endinterface

// ----- rtl/stepper_wave_drive_sequencer.sv -----
`timescale 1ns / 1ps
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result side takes results; the state
// update is a single pass from the input register to the result register, and
// the angle-to-step division is a reciprocal multiply in that same pass.
// Reset: all coils off, idle, phase_ticks = 1, both pipeline stages empty.
// ----------------------------------------------------------------------------
// stepper_wave_drive_sequencer - four-phase wave drive stepper sequencer
// Takes tick and move items, energizes one coil at a time, reports status.
// ----------------------------------------------------------------------------
module stepper_wave_drive_sequencer #(
  parameter int unsigned STEPS_PER_REV = swds_pkg::STEPS_PER_REV_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swds_pkg::TICKS_W-1:0]  cfg_wdata_i,
  swds_cmd_if.sink                      item_i,
  swds_res_if.source                    result_o
);

  // angle * STEPS_PER_REV, formed at the port and held in the input register
  localparam int unsigned PROD_W = swds_pkg::ANGLE_W + $clog2(STEPS_PER_REV + 1);
  // 360 = 8 * 45: drop three bits, then divide by 45 with a reciprocal
  localparam int unsigned X_W    = PROD_W - 3;
  localparam int unsigned DIV_K  = X_W + 6;
  localparam int unsigned MULT_W = DIV_K - 5;
  localparam longint unsigned MULT_L = ((64'd1 << DIV_K) + 64'd44) / 64'd45;
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);
  localparam int unsigned WIDE_W = X_W + MULT_W;
  localparam int unsigned EXT_W  = X_W + swds_pkg::STEPS_W;

  // --------------------------------------------------------------------------
  // Handshake: input register feeds the result register each cycle the result
  // side can take an item.
  // --------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic adv;

  assign adv          = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;
  assign result_o.valid = out_valid_q;

  // Input register payload
  logic [swds_pkg::KIND_W-1:0] kind_q;
  logic [swds_pkg::DIR_W-1:0]  dir_q;
  logic [PROD_W-1:0]           prod_q;

  // Move state
  logic [swds_pkg::TICKS_W-1:0] phase_ticks_q;
  logic [swds_pkg::STEPS_W-1:0] steps_q, steps_d;
  logic [1:0]                   phase_q, phase_d;
  logic [swds_pkg::TICKS_W-1:0] wait_q, wait_d;
  logic                         reverse_q, reverse_d;
  logic [swds_pkg::COILS_W-1:0] coil_q, coil_d;
  logic                         moving_q, moving_d;

  // Result register payload
  logic [swds_pkg::COILS_W-1:0]  res_coils_q;
  logic                          res_busy_q;
  logic                          res_done_q;
  logic [swds_pkg::STATUS_W-1:0] res_status_q;

  // --------------------------------------------------------------------------
  // Step count: floor(prod / 360), saturated to the step counter width.
  // --------------------------------------------------------------------------
  logic [X_W-1:0]                x_val;
  logic [WIDE_W-1:0]             wide;
  logic [X_W-1:0]                quot;
  logic [EXT_W-1:0]              quot_ext;
  logic [swds_pkg::STEPS_W-1:0]  steps_sat;

  assign x_val    = prod_q[PROD_W-1:3];
  assign wide     = WIDE_W'(x_val) * WIDE_W'(MULT);
  assign quot     = X_W'(wide >> DIV_K);
  assign quot_ext = EXT_W'(quot);
  assign steps_sat = (quot_ext > EXT_W'(swds_pkg::STEPS_MAX)) ? swds_pkg::STEPS_MAX
                                                               : quot_ext[swds_pkg::STEPS_W-1:0];

  // --------------------------------------------------------------------------
  // Per-item state update
  // --------------------------------------------------------------------------
  logic [swds_pkg::TICKS_W-1:0] wait_next;
  logic [1:0]                   coil_idx;
  logic                         done;
  swds_pkg::status_e            status;

  assign wait_next = wait_q + swds_pkg::TICKS_W'(1);
  assign coil_idx  = reverse_q ? (2'd3 - phase_q) : phase_q;

  always_comb begin
    steps_d   = steps_q;
    phase_d   = phase_q;
    wait_d    = wait_q;
    reverse_d = reverse_q;
    coil_d    = coil_q;
    moving_d  = moving_q;
    done      = 1'b0;
    status    = swds_pkg::STATUS_NONE;
    if (kind_q == swds_pkg::KIND_MOVE) begin
      if (moving_q) begin
        // busy check comes before the direction check
        status = swds_pkg::STATUS_BUSY;
      end else if (dir_q[1]) begin
        status = swds_pkg::STATUS_BAD_DIR;
      end else begin
        status    = swds_pkg::STATUS_ACCEPT;
        reverse_d = dir_q[0];
        phase_d   = 2'd0;
        wait_d    = '0;
        steps_d   = steps_sat;
        if (steps_sat == '0) begin
          done = 1'b1;
        end else begin
          moving_d = 1'b1;
        end
      end
    end else if (moving_q) begin
      // fire on reaching phase_ticks; a zero setting fires every tick
      if ((wait_next >= phase_ticks_q) || (wait_next == '0)) begin
        coil_d  = swds_pkg::COILS_W'(1) << coil_idx;
        wait_d  = '0;
        phase_d = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          steps_d = steps_q - swds_pkg::STEPS_W'(1);
          if (steps_d == '0) begin
            moving_d = 1'b0;
            done     = 1'b1;
          end
        end
      end else begin
        wait_d = wait_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_ticks_q <= swds_pkg::PHASE_TICKS_RST;
      steps_q       <= '0;
      phase_q       <= 2'd0;
      wait_q        <= '0;
      reverse_q     <= 1'b0;
      coil_q        <= '0;
      moving_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
      // hold an item in the input register until the result side frees up
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        steps_q     <= steps_d;
        phase_q     <= phase_d;
        wait_q      <= wait_d;
        reverse_q   <= reverse_d;
        coil_q      <= coil_d;
        moving_q    <= moving_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the item with its scaled angle, and the result
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      kind_q <= item_i.kind;
      dir_q  <= item_i.direction;
      prod_q <= PROD_W'(item_i.angle) * PROD_W'(STEPS_PER_REV);
    end
    if (adv) begin
      res_coils_q  <= coil_d;
      res_busy_q   <= moving_d;
      res_done_q   <= done;
      res_status_q <= status;
    end
  end

  assign result_o.coils    = res_coils_q;
  assign result_o.busy_res = res_busy_q;
  assign result_o.done_res = res_done_q;
  assign result_o.status   = res_status_q;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - stepper wave drive sequencer testbench
// Drives tick and move items into the sequencer, predicts the coil drive and
// status of every item in a scoreboard, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STEPS       = swds_pkg::STEPS_PER_REV_DEF;
  localparam int unsigned MOVE_TARGET = 1450;

  // Direction codes carried by a move item.
  localparam logic [swds_pkg::DIR_W-1:0] DIR_FWD  = 2'd0;
  localparam logic [swds_pkg::DIR_W-1:0] DIR_REV  = 2'd1;
  localparam logic [swds_pkg::DIR_W-1:0] DIR_ERR2 = 2'd2;
  localparam logic [swds_pkg::DIR_W-1:0] DIR_ERR3 = 2'd3;

  typedef struct {
    logic [swds_pkg::COILS_W-1:0] coils;
    logic                         busy;
    logic                         done;
    swds_pkg::status_e            status;
  } drive_t;

  // Tracks the motor state and holds the coil drive expected for each item
  // that went in but has not come out yet.
  class coil_drive_board;
    logic [swds_pkg::TICKS_W-1:0] phase_ticks;
    logic [swds_pkg::STEPS_W-1:0] steps_left;
    logic [1:0]                   phase_index;
    logic [swds_pkg::TICKS_W-1:0] wait_count;
    logic                         move_reverse;
    logic [swds_pkg::COILS_W-1:0] coil_state;
    logic                         moving;
    drive_t                       pending[$];
    int unsigned                  errors;

    function new();
      phase_ticks  = swds_pkg::PHASE_TICKS_RST;
      steps_left   = '0;
      phase_index  = '0;
      wait_count   = '0;
      move_reverse = 1'b0;
      coil_state   = '0;
      moving       = 1'b0;
      errors       = 0;
    endfunction

    function void write_ticks(logic [swds_pkg::TICKS_W-1:0] value);
      phase_ticks = value;
    endfunction

    function void note_item(logic [swds_pkg::KIND_W-1:0] kind,
                            logic [swds_pkg::DIR_W-1:0] direction,
                            logic [swds_pkg::ANGLE_W-1:0] angle);
      logic [63:0]                  steps;
      logic [swds_pkg::TICKS_W-1:0] next;
      logic [1:0]                   coil;
      drive_t                       drive;
      drive.done   = 1'b0;
      drive.status = swds_pkg::STATUS_NONE;
      if (kind == swds_pkg::KIND_MOVE) begin
        // busy check wins over the direction check
        if (moving) begin
          drive.status = swds_pkg::STATUS_BUSY;
        end else if (direction > DIR_REV) begin
          drive.status = swds_pkg::STATUS_BAD_DIR;
        end else begin
          steps = 64'(angle) * 64'(STEPS) / 64'(swds_pkg::DEG_PER_REV);
          if (steps > 64'(swds_pkg::STEPS_MAX)) begin
            steps = 64'(swds_pkg::STEPS_MAX);
          end
          drive.status = swds_pkg::STATUS_ACCEPT;
          move_reverse = (direction == DIR_REV);
          phase_index  = '0;
          wait_count   = '0;
          steps_left   = steps[swds_pkg::STEPS_W-1:0];
          if (steps_left == '0) begin
            drive.done = 1'b1;
          end else begin
            moving = 1'b1;
          end
        end
      end else if (moving) begin
        next = wait_count + 1'b1;
        // a phase count of zero behaves as one
        if (next >= phase_ticks || next == '0) begin
          coil        = move_reverse ? 2'd3 - phase_index : phase_index;
          coil_state  = 4'b0001 << coil;
          wait_count  = '0;
          phase_index = phase_index + 1'b1;
          if (phase_index == '0) begin
            steps_left = steps_left - 1'b1;
            if (steps_left == '0) begin
              moving     = 1'b0;
              drive.done = 1'b1;
            end
          end
        end else begin
          wait_count = next;
        end
      end
      drive.coils = coil_state;
      drive.busy  = moving;
      pending.push_back(drive);
    endfunction

    function void check_drive(logic [swds_pkg::COILS_W-1:0] coils, logic busy, logic done,
                              logic [swds_pkg::STATUS_W-1:0] status);
      drive_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result coils=%b busy=%b done=%b status=%0d",
                 $time, coils, busy, done, status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (coils !== want.coils || busy !== want.busy || done !== want.done ||
          status !== want.status) begin
        $display("%0t: mismatch expected coils=%b busy=%b done=%b status=%0d",
                 $time, want.coils, want.busy, want.done, want.status);
        $display("%0t:          actual   coils=%b busy=%b done=%b status=%0d",
                 $time, coils, busy, done, status);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [swds_pkg::TICKS_W-1:0] cfg_wdata_i;

  swds_cmd_if item_if ();
  swds_res_if result_if ();

  coil_drive_board board = new();

  // Flags shared between the item driver and the result sink, and the driver's item count.
  bit          steady      = 1'b0;
  int unsigned hold_req    = 0;
  int unsigned moved_items = 0;

  stepper_wave_drive_sequencer #(
    .STEPS_PER_REV(STEPS)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .item_i  (item_if),
    .result_o(result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("** stepper_wave_drive_sequencer: FAILED **");
    $finish;
  end

  // Result sink: check every accepted result, stall at random, and hold off
  // for a long stretch when the driver asks for it.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        board.check_drive(result_if.coils, result_if.busy_res, result_if.done_res,
                          result_if.status);
      end
      if (hold_req != 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        result_if.ready <= steady || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Offer one item, idling first at random; note it once it is taken. Valid
  // stays high on return so back-to-back items need no lowering.
  task automatic send_item(logic [swds_pkg::KIND_W-1:0] kind,
                           logic [swds_pkg::DIR_W-1:0] direction,
                           logic [swds_pkg::ANGLE_W-1:0] angle);
    if (!steady && $urandom_range(0, 99) < 24) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.kind      <= kind;
    item_if.direction <= direction;
    item_if.angle     <= angle;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    board.note_item(kind, direction, angle);
  endtask

  // Tick with junk in the unused fields.
  task automatic tick();
    send_item(swds_pkg::KIND_TICK, swds_pkg::DIR_W'($urandom),
              swds_pkg::ANGLE_W'($urandom));
  endtask

  // Drop valid and wait until every result is back.
  task automatic drain();
    item_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_phase_ticks(logic [swds_pkg::TICKS_W-1:0] value);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.write_ticks(value);
    cfg_we_i <= 1'b0;
  endtask

  // Stray item: a rejected command while moving; otherwise an idle tick or a
  // command with a bad direction.
  task automatic noise_item();
    logic [swds_pkg::DIR_W-1:0] direction;
    if (board.moving) begin
      direction = swds_pkg::DIR_W'($urandom);
    end else begin
      direction = $urandom_range(0, 1) ? DIR_ERR3 : DIR_ERR2;
    end
    if (board.moving || $urandom_range(0, 1) == 0) begin
      send_item(swds_pkg::KIND_MOVE, direction, swds_pkg::ANGLE_W'($urandom));
    end else begin
      tick();
    end
  endtask

  // Start a move and tick it to the end, mixing in stray items and phase
  // count changes at the given rates.
  task automatic run_move(logic [swds_pkg::DIR_W-1:0] direction,
                          logic [swds_pkg::ANGLE_W-1:0] angle,
                          int unsigned noise_pct, int unsigned retune_pct);
    int unsigned roll;
    send_item(swds_pkg::KIND_MOVE, direction, angle);
    moved_items++;
    while (board.moving) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        noise_item();
      end else if (roll < noise_pct + retune_pct) begin
        write_phase_ticks(swds_pkg::TICKS_W'($urandom_range(1, 5)));
      end else begin
        tick();
        moved_items++;
      end
    end
  endtask

  initial begin : item_driver
    int unsigned roll;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    item_if.valid     <= 1'b0;
    item_if.kind      <= swds_pkg::KIND_TICK;
    item_if.direction <= DIR_FWD;
    item_if.angle     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle tick, bad directions, zero-step move, both directions.
    tick();
    send_item(swds_pkg::KIND_MOVE, DIR_ERR2, '1);
    send_item(swds_pkg::KIND_MOVE, DIR_ERR3, '0);
    send_item(swds_pkg::KIND_MOVE, DIR_FWD, '0);
    send_item(swds_pkg::KIND_MOVE, DIR_FWD, 16'd1);
    tick();
    tick();
    // busy must be reported ahead of the bad direction
    send_item(swds_pkg::KIND_MOVE, DIR_ERR3, '1);
    while (board.moving) tick();
    run_move(DIR_REV, 16'd1, 0, 0);
    // a phase count of zero acts as one
    write_phase_ticks('0);
    run_move(DIR_FWD, 16'd1, 0, 0);
    // longest phase count, then cut it below the wait already counted: the
    // next tick must fire the phase at once
    write_phase_ticks('1);
    send_item(swds_pkg::KIND_MOVE, DIR_REV, 16'd1);
    repeat (3) tick();
    write_phase_ticks(16'd2);
    while (board.moving) tick();

    // Back pressure: hold the results off while ticks keep coming, so the
    // block fills and stalls its input; then pause until all is back.
    write_phase_ticks(16'd1);
    send_item(swds_pkg::KIND_MOVE, DIR_FWD, 16'd25);
    hold_req = 60;
    while (board.moving) tick();
    drain();

    // Random moves with short angles, stray items and phase count changes;
    // one stretch runs without any idling.
    while (moved_items < MOVE_TARGET) begin
      steady = (moved_items >= 700 && moved_items < 1000);
      roll   = $urandom_range(0, 99);
      if (roll < 8) begin
        write_phase_ticks(swds_pkg::TICKS_W'($urandom_range(1, 4)));
      end else if (roll < 20) begin
        noise_item();
      end else begin
        run_move($urandom_range(0, 1) ? DIR_REV : DIR_FWD,
                 swds_pkg::ANGLE_W'($urandom_range(0, 6)), 6, 2);
      end
    end
    steady = 1'b0;

    // Largest angle: accept it, step a little, and leave it running.
    write_phase_ticks(16'd1);
    send_item(swds_pkg::KIND_MOVE, DIR_REV, '1);
    repeat (12) tick();
    send_item(swds_pkg::KIND_MOVE, DIR_FWD, '1);
    drain();
    repeat (8) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** stepper_wave_drive_sequencer: PASSED **");
    end else begin
      $display("** stepper_wave_drive_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/swds_pkg.sv
rtl/swds_cmd_if.sv
rtl/swds_res_if.sv
rtl/stepper_wave_drive_sequencer.sv
dv/tb.sv
